// File: design/assert_macros.svh
// assertion helpers used by the checker file cps_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("assertion lbl failed");

// clocked property that also holds during reset
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
   else $error("assertion lbl failed");

`endif

// File: design/cps_pkg.sv
`default_nettype none
package cps_pkg;

   localparam logic [3:0] KIND_FILL      = 4'd5;
   localparam logic [3:0] KIND_FILL_LONG = 4'd6;
   localparam logic [3:0] KIND_PROCESS   = 4'd7;
   localparam logic [3:0] KIND_SHORT     = 4'd8;

   localparam logic       CSR_BRIDGE_ID = 1'b0;
   localparam logic       CSR_DEST_ID   = 1'b1;

   localparam logic [7:0] BRIDGE_ID_RESET = 8'd254;
   localparam logic [7:0] DEST_ID_RESET   = 8'd69;

   localparam int         CHUNK_BYTES      = 7;
   localparam logic [2:0] CHUNK_SIZE_SHORT = 3'd7;
   localparam logic [2:0] CHUNK_SIZE_LONG  = 3'd6;
   localparam logic [15:0] SHORT_MSG_MAX   = 16'd6;
   localparam logic [15:0] OFFSET_BYTE_MAX = 16'd255;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef struct packed {
      logic [11:0]     can_id;
      logic [3:0]      frame_len;
      logic [7:0][7:0] data;
      logic            message_done;
      logic            too_long;
   } frame_type;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: design/cps_channels.sv
`default_nettype none
interface cps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cps_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] can_id;
   logic [3:0]  frame_len;
   logic [7:0]  frame_b0;
   logic [7:0]  frame_b1;
   logic [7:0]  frame_b2;
   logic [7:0]  frame_b3;
   logic [7:0]  frame_b4;
   logic [7:0]  frame_b5;
   logic [7:0]  frame_b6;
   logic [7:0]  frame_b7;
   logic        message_done;
   logic        too_long;

   modport source (output valid, output can_id, output frame_len,
                   output frame_b0, output frame_b1, output frame_b2, output frame_b3,
                   output frame_b4, output frame_b5, output frame_b6, output frame_b7,
                   output message_done, output too_long, input ready);
   modport sink   (input valid, input can_id, input frame_len,
                   input frame_b0, input frame_b1, input frame_b2, input frame_b3,
                   input frame_b4, input frame_b5, input frame_b6, input frame_b7,
                   input message_done, input too_long, output ready);
endinterface
`default_nettype wire

// File: design/cps_frame_builder.sv
`default_nettype none
module cps_frame_builder #(
   parameter int MAX_PAYLOAD = 512,
   parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   input  wire logic [7:0]       bridge_id,
   input  wire logic [7:0]       dest_id,
   input  wire logic [CNT_W-1:0] byte_count,
   input  wire logic [CNT_W-1:0] chunk_start,
   input  wire logic [2:0]       pending_count,
   input  wire logic [7:0]       pending_bytes [cps_pkg::CHUNK_BYTES],
   input  wire logic [15:0]      running_crc,
   input  wire logic             overflowed,
   output logic [CNT_W-1:0]      byte_count_in,
   output logic [CNT_W-1:0]      chunk_start_in,
   output logic [2:0]            pending_count_in,
   output logic [15:0]           running_crc_in,
   output logic                  overflowed_in,
   output logic                  pending_wr,
   output logic [1:0]            frame_cnt,
   output cps_pkg::frame_type    frame_a,
   output cps_pkg::frame_type    frame_b
);

   logic [CNT_W-1:0]   count_next;
   logic [2:0]         pend_next;
   logic [15:0]        crc_next;
   logic               full;
   logic               long_offset;
   logic               short_sent;
   logic [15:0]        start16;
   logic [15:0]        count16;
   logic [7:0]         eff [cps_pkg::CHUNK_BYTES];
   cps_pkg::frame_type short_frame;
   cps_pkg::frame_type fill_frame;
   cps_pkg::frame_type tail_frame;

   assign count_next  = byte_count + CNT_W'(1);
   assign pend_next   = pending_count + 3'd1;
   assign crc_next    = cps_pkg::crc16_step(running_crc, data_byte);
   assign full        = (byte_count >= CNT_W'(MAX_PAYLOAD));
   assign start16     = 16'(chunk_start);
   assign count16     = 16'(count_next);
   assign long_offset = (start16 > cps_pkg::OFFSET_BYTE_MAX);

   // pending bytes with the incoming byte merged in, zero past the fill level
   always_comb begin
      for (int i = 0; i < cps_pkg::CHUNK_BYTES; i++) begin
         if (3'(i) == pending_count) begin
            eff[i] = data_byte;
         end else if (3'(i) < pending_count) begin
            eff[i] = pending_bytes[i];
         end else begin
            eff[i] = 8'h00;
         end
      end
   end

   always_comb begin
      short_frame              = '0;
      short_frame.can_id       = {cps_pkg::KIND_SHORT, dest_id};
      short_frame.frame_len    = 4'(pend_next) + 4'd2;
      short_frame.data[0]      = bridge_id;
      short_frame.message_done = 1'b1;
      for (int i = 0; i < 6; i++) begin
         short_frame.data[2+i] = eff[i];
      end

      fill_frame = '0;
      if (long_offset) begin
         fill_frame.can_id    = {cps_pkg::KIND_FILL_LONG, dest_id};
         fill_frame.frame_len = 4'(pend_next) + 4'd2;
         fill_frame.data[0]   = start16[15:8];
         fill_frame.data[1]   = start16[7:0];
         for (int i = 0; i < 6; i++) begin
            fill_frame.data[2+i] = eff[i];
         end
      end else begin
         fill_frame.can_id    = {cps_pkg::KIND_FILL, dest_id};
         fill_frame.frame_len = 4'(pend_next) + 4'd1;
         fill_frame.data[0]   = start16[7:0];
         for (int i = 0; i < 7; i++) begin
            fill_frame.data[1+i] = eff[i];
         end
      end

      tail_frame              = '0;
      tail_frame.message_done = 1'b1;
      if (overflowed || full) begin
         tail_frame.too_long = 1'b1;
      end else begin
         tail_frame.can_id    = {cps_pkg::KIND_PROCESS, dest_id};
         tail_frame.frame_len = 4'd6;
         tail_frame.data[0]   = bridge_id;
         tail_frame.data[2]   = count16[15:8];
         tail_frame.data[3]   = count16[7:0];
         tail_frame.data[4]   = crc_next[15:8];
         tail_frame.data[5]   = crc_next[7:0];
      end
   end

   always_comb begin
      byte_count_in    = byte_count;
      chunk_start_in   = chunk_start;
      pending_count_in = pending_count;
      running_crc_in   = running_crc;
      overflowed_in    = overflowed;
      pending_wr       = 1'b0;
      frame_cnt        = 2'd0;
      frame_a          = '0;
      frame_b          = '0;
      short_sent       = 1'b0;

      if (!overflowed) begin
         if (full) begin
            overflowed_in = 1'b1;
         end else begin
            running_crc_in   = crc_next;
            pending_wr       = 1'b1;
            pending_count_in = pend_next;
            byte_count_in    = count_next;
            if (last_byte && (count16 <= cps_pkg::SHORT_MSG_MAX)) begin
               frame_a    = short_frame;
               frame_cnt  = 2'd1;
               short_sent = 1'b1;
            end else if (last_byte || (pend_next >= (long_offset ? cps_pkg::CHUNK_SIZE_LONG
                                                                 : cps_pkg::CHUNK_SIZE_SHORT)))
            begin
               frame_a          = fill_frame;
               frame_cnt        = 2'd1;
               chunk_start_in   = chunk_start + CNT_W'(pend_next);
               pending_count_in = 3'd0;
            end
         end
      end

      if (last_byte && !short_sent) begin
         if (frame_cnt == 2'd1) begin
            frame_b   = tail_frame;
            frame_cnt = 2'd2;
         end else begin
            frame_a   = tail_frame;
            frame_cnt = 2'd1;
         end
      end

      // end of message returns all message state to its idle values
      if (last_byte) begin
         byte_count_in    = '0;
         chunk_start_in   = '0;
         pending_count_in = 3'd0;
         running_crc_in   = 16'h0000;
         overflowed_in    = 1'b0;
      end
   end

endmodule
`default_nettype wire

// File: design/can_payload_segmenter.sv
// output: first frame of a byte is on rsp in the cycle after the byte transfer;
//   a second frame (process or error after a fill) waits in next_ff behind it
// throughput: one byte per cycle while rsp is ready; a byte that yields two
//   frames holds off the next byte until the two-entry queue has drained to its head
// reset: synchronous, clears message state, output queue and node ids (254, 69)
`default_nettype none
module can_payload_segmenter #(
   parameter int MAX_PAYLOAD = 512
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cps_req_if.sink    req_ch,
   cps_rsp_if.source  rsp_ch,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_index,
   input  wire logic [7:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

   logic [7:0]         bridge_id_ff;
   logic [7:0]         dest_id_ff;
   logic [CNT_W-1:0]   byte_count_ff;
   logic [CNT_W-1:0]   byte_count_in;
   logic [CNT_W-1:0]   chunk_start_ff;
   logic [CNT_W-1:0]   chunk_start_in;
   logic [2:0]         pending_count_ff;
   logic [2:0]         pending_count_in;
   logic [15:0]        running_crc_ff;
   logic [15:0]        running_crc_in;
   logic               overflowed_ff;
   logic               overflowed_in;
   logic [7:0]         pending_bytes_ff [cps_pkg::CHUNK_BYTES];
   logic               pending_wr;
   logic [1:0]         frame_cnt;
   cps_pkg::frame_type frame_a;
   cps_pkg::frame_type frame_b;

   cps_pkg::frame_type head_ff;
   cps_pkg::frame_type head_in;
   cps_pkg::frame_type next_ff;
   cps_pkg::frame_type next_in;
   logic               head_vld_ff;
   logic               head_vld_in;
   logic               next_vld_ff;
   logic               next_vld_in;

   logic               req_xfer;
   logic               rsp_xfer;

   cps_frame_builder #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .CNT_W       (CNT_W)
   ) u_builder (
      .data_byte        (req_ch.data_byte),
      .last_byte        (req_ch.last_byte),
      .bridge_id        (bridge_id_ff),
      .dest_id          (dest_id_ff),
      .byte_count       (byte_count_ff),
      .chunk_start      (chunk_start_ff),
      .pending_count    (pending_count_ff),
      .pending_bytes    (pending_bytes_ff),
      .running_crc      (running_crc_ff),
      .overflowed       (overflowed_ff),
      .byte_count_in    (byte_count_in),
      .chunk_start_in   (chunk_start_in),
      .pending_count_in (pending_count_in),
      .running_crc_in   (running_crc_in),
      .overflowed_in    (overflowed_in),
      .pending_wr       (pending_wr),
      .frame_cnt        (frame_cnt),
      .frame_a          (frame_a),
      .frame_b          (frame_b)
   );

   // room for two frames once the head leaves
   assign req_ch.ready = !head_vld_ff || (!next_vld_ff && rsp_ch.ready);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_xfer     = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      head_in     = head_ff;
      next_in     = next_ff;
      head_vld_in = head_vld_ff;
      next_vld_in = next_vld_ff;
      if (rsp_xfer) begin
         head_in     = next_ff;
         head_vld_in = next_vld_ff;
         next_vld_in = 1'b0;
      end
      if (req_xfer) begin
         head_in     = frame_a;
         next_in     = frame_b;
         head_vld_in = (frame_cnt != 2'd0);
         next_vld_in = (frame_cnt == 2'd2);
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      next_ff <= next_in;
      if (req_xfer && pending_wr) begin
         pending_bytes_ff[pending_count_ff] <= req_ch.data_byte;
      end
      if (reset) begin
         head_vld_ff      <= 1'b0;
         next_vld_ff      <= 1'b0;
         byte_count_ff    <= '0;
         chunk_start_ff   <= '0;
         pending_count_ff <= 3'd0;
         running_crc_ff   <= 16'h0000;
         overflowed_ff    <= 1'b0;
         bridge_id_ff     <= cps_pkg::BRIDGE_ID_RESET;
         dest_id_ff       <= cps_pkg::DEST_ID_RESET;
      end else begin
         head_vld_ff <= head_vld_in;
         next_vld_ff <= next_vld_in;
         if (req_xfer) begin
            byte_count_ff    <= byte_count_in;
            chunk_start_ff   <= chunk_start_in;
            pending_count_ff <= pending_count_in;
            running_crc_ff   <= running_crc_in;
            overflowed_ff    <= overflowed_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               cps_pkg::CSR_BRIDGE_ID: bridge_id_ff <= csr_wdata;
               cps_pkg::CSR_DEST_ID:   dest_id_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_ch.valid        = head_vld_ff;
   assign rsp_ch.can_id       = head_ff.can_id;
   assign rsp_ch.frame_len    = head_ff.frame_len;
   assign rsp_ch.frame_b0     = head_ff.data[0];
   assign rsp_ch.frame_b1     = head_ff.data[1];
   assign rsp_ch.frame_b2     = head_ff.data[2];
   assign rsp_ch.frame_b3     = head_ff.data[3];
   assign rsp_ch.frame_b4     = head_ff.data[4];
   assign rsp_ch.frame_b5     = head_ff.data[5];
   assign rsp_ch.frame_b6     = head_ff.data[6];
   assign rsp_ch.frame_b7     = head_ff.data[7];
   assign rsp_ch.message_done = head_ff.message_done;
   assign rsp_ch.too_long     = head_ff.too_long;

endmodule
`default_nettype wire

// File: design/cps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] can_id,
   input wire logic [3:0]  frame_len,
   input wire logic [7:0]  frame_b0,
   input wire logic        message_done,
   input wire logic        too_long
);

   logic [24:0] rsp_word;

   assign rsp_word = {can_id, frame_len, frame_b0, too_long};

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_word))
   `ASSERT_CLK(a_len_range, clock, reset || !rsp_valid || (frame_len <= 4'd8))
   `ASSERT_CLK_RST(a_error_frame, clock, reset, rsp_valid && too_long |-> message_done && (can_id == 12'd0) && (frame_len == 4'd0))

endmodule

bind can_payload_segmenter cps_checker u_cps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .can_id       (rsp_ch.can_id),
   .frame_len    (rsp_ch.frame_len),
   .frame_b0     (rsp_ch.frame_b0),
   .message_done (rsp_ch.message_done),
   .too_long     (rsp_ch.too_long)
);
`default_nettype wire

// File: sim/segment_frame_checker.sv
module segment_frame_checker #(
   parameter int MAX_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   cps_req_if         req_mon,
   cps_rsp_if         rsp_mon,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         frames_due
);

   localparam logic [15:0] XMODEM_POLY = 16'h1021;

   logic [7:0]  bridge_id;
   logic [7:0]  dest_id;
   logic [9:0]  byte_count;
   logic [9:0]  chunk_start;
   logic [7:0]  pending_bytes [7];
   logic [2:0]  pending_count;
   logic [15:0] running_crc;
   logic        overflowed;

   cps_pkg::frame_type expected_frames [$];
   cps_pkg::frame_type got;
   cps_pkg::frame_type want;

   function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc, input logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
         fb  = crc[15] ^ b[k];
         crc = {crc[14:0], 1'b0} ^ (fb ? XMODEM_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function automatic cps_pkg::frame_type build_frame(input logic [3:0] kind,
                                                      input logic [3:0] len,
                                                      input logic [7:0][7:0] payload,
                                                      input logic done, input logic err);
      cps_pkg::frame_type f;
      f.can_id       = err ? 12'h000 : {kind, dest_id};
      f.frame_len    = len;
      f.message_done = done;
      f.too_long     = err;
      for (int j = 0; j < 8; j++) begin
         f.data[j] = (j < len) ? payload[j] : 8'h00;
      end
      return f;
   endfunction

   task automatic clear_message();
      byte_count    = '0;
      chunk_start   = '0;
      pending_count = '0;
      running_crc   = '0;
      overflowed    = 1'b0;
      for (int j = 0; j < 7; j++) begin
         pending_bytes[j] = 8'h00;
      end
   endtask

   task automatic predict_frames(input logic [7:0] b, input logic is_last);
      logic [7:0][7:0] fr;
      logic            long_chunk;
      logic [2:0]      chunk_size;
      logic            message_closed;
      fr             = '0;
      message_closed = 1'b0;
      if (!overflowed) begin
         if (byte_count >= MAX_BYTES) begin
            overflowed = 1'b1;
         end else begin
            long_chunk  = chunk_start > 10'd255;
            chunk_size  = long_chunk ? 3'd6 : 3'd7;
            running_crc = crc_xmodem_byte(running_crc, b);
            if (pending_count < 3'd7) begin
               pending_bytes[pending_count] = b;
               pending_count++;
            end
            byte_count++;
            if (is_last && byte_count <= 10'd6) begin
               fr[0] = bridge_id;
               for (int j = 0; j < pending_count; j++) begin
                  fr[2 + j] = pending_bytes[j];
               end
               expected_frames.push_back(build_frame(cps_pkg::KIND_SHORT,
                                                     {1'b0, pending_count} + 4'd2,
                                                     fr, 1'b1, 1'b0));
               clear_message();
               message_closed = 1'b1;
            end else if (pending_count >= chunk_size || (is_last && pending_count != 0)) begin
               if (!long_chunk) begin
                  fr[0] = chunk_start[7:0];
                  for (int j = 0; j < pending_count; j++) begin
                     fr[1 + j] = pending_bytes[j];
                  end
                  expected_frames.push_back(build_frame(cps_pkg::KIND_FILL,
                                                        {1'b0, pending_count} + 4'd1,
                                                        fr, 1'b0, 1'b0));
               end else begin
                  fr[0] = {6'b0, chunk_start[9:8]};
                  fr[1] = chunk_start[7:0];
                  for (int j = 0; j < pending_count; j++) begin
                     fr[2 + j] = pending_bytes[j];
                  end
                  expected_frames.push_back(build_frame(cps_pkg::KIND_FILL_LONG,
                                                        {1'b0, pending_count} + 4'd2,
                                                        fr, 1'b0, 1'b0));
               end
               chunk_start   = chunk_start + pending_count;
               pending_count = '0;
            end
         end
      end
      if (is_last && !message_closed) begin
         fr = '0;
         if (overflowed) begin
            expected_frames.push_back(build_frame(4'd0, 4'd0, fr, 1'b1, 1'b1));
         end else begin
            fr[0] = bridge_id;
            fr[2] = {6'b0, byte_count[9:8]};
            fr[3] = byte_count[7:0];
            fr[4] = running_crc[15:8];
            fr[5] = running_crc[7:0];
            expected_frames.push_back(build_frame(cps_pkg::KIND_PROCESS, 4'd6, fr,
                                                  1'b1, 1'b0));
         end
         clear_message();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [15:0] g, input logic [15:0] w);
      if (g !== w) begin
         report_mismatch($sformatf("%s got %0h expected %0h", field, g, w));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bridge_id = cps_pkg::BRIDGE_ID_RESET;
         dest_id   = cps_pkg::DEST_ID_RESET;
         clear_message();
         expected_frames.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == cps_pkg::CSR_BRIDGE_ID) begin
               bridge_id = csr_wdata;
            end else begin
               dest_id = csr_wdata;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.can_id       = rsp_mon.can_id;
            got.frame_len    = rsp_mon.frame_len;
            got.data         = {rsp_mon.frame_b7, rsp_mon.frame_b6, rsp_mon.frame_b5,
                                rsp_mon.frame_b4, rsp_mon.frame_b3, rsp_mon.frame_b2,
                                rsp_mon.frame_b1, rsp_mon.frame_b0};
            got.message_done = rsp_mon.message_done;
            got.too_long     = rsp_mon.too_long;
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected frame id %0h len %0d",
                                         got.can_id, got.frame_len));
            end else begin
               want = expected_frames.pop_front();
               check_field("can_id", got.can_id, want.can_id);
               check_field("frame_len", got.frame_len, want.frame_len);
               for (int j = 0; j < 8; j++) begin
                  check_field($sformatf("frame_b%0d", j), got.data[j], want.data[j]);
               end
               check_field("message_done", got.message_done, want.message_done);
               check_field("too_long", got.too_long, want.too_long);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_frames(req_mon.data_byte, req_mon.last_byte);
         end
      end
      frames_due <= expected_frames.size();
   end

endmodule

// File: sim/tb_can_payload_segmenter.sv
module tb_can_payload_segmenter;

   localparam int MAX_PAYLOAD  = 512;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 45;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en;
   logic       csr_index;
   logic [7:0] csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;
   int mismatches;
   int frames_due;
   int phase_bytes;
   int msg_len;

   cps_req_if req_ch ();
   cps_rsp_if rsp_ch ();

   can_payload_segmenter #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   segment_frame_checker #(
      .MAX_BYTES(MAX_PAYLOAD)
   ) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mismatches(mismatches),
      .frames_due(frames_due)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // no transfer on either channel for too long means the block hung
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= is_last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // every frame in, then a drain wait for anything still in flight
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (frames_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_index        <= cps_pkg::CSR_BRIDGE_ID;
      csr_wdata        <= 8'h00;
      send_idle_pct    = 14;
      recv_idle_pct    = 60;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short frames at both size limits, then fill frames around one full chunk
      send_byte(8'h00, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_byte(8'hFF, i == 5);
      end
      for (int i = 0; i < 7; i++) begin
         send_byte(8'(i * 37), i == 6);
      end
      for (int i = 0; i < 8; i++) begin
         send_byte(8'h01 << i, i == 7);
      end

      for (int phase = 0; phase < 3; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_csr(cps_pkg::CSR_BRIDGE_ID, 8'hFF);
               write_csr(cps_pkg::CSR_DEST_ID, 8'hFF);
               send_idle_pct = 14;
               recv_idle_pct = 60;
            end
            1: begin
               write_csr(cps_pkg::CSR_BRIDGE_ID, 8'h00);
               write_csr(cps_pkg::CSR_DEST_ID, 8'h00);
               send_idle_pct = 60;
               recv_idle_pct = 14;
            end
            default: begin
               write_csr(cps_pkg::CSR_BRIDGE_ID, 8'($urandom_range(255)));
               write_csr(cps_pkg::CSR_DEST_ID, 8'($urandom_range(255)));
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            msg_len = ($urandom_range(9) < 6) ? int'($urandom_range(1, 8))
                                              : int'($urandom_range(9, 40));
            send_message(msg_len);
            phase_bytes += msg_len;
         end
         // one overflowing message: two-byte offsets, the size limit, the overflow
         if (phase == 2) begin
            send_message(int'($urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 12)));
         end
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
